>>> src/lnr_pkg.sv
// ---------------------------------------------------------------------------
// lnr_pkg
// Shared types and constants of the letterbox nearest-neighbor resizer.
// ---------------------------------------------------------------------------
package lnr_pkg;

  // Default sizes of the frame store and of the destination image.
  localparam int unsigned MAX_SRC_W_DEF   = 512;
  localparam int unsigned MAX_SRC_H_DEF   = 512;
  localparam int unsigned MAX_DST_DIM_DEF = 1024;

  // Field widths.
  localparam int unsigned POS_W     = 10;
  localparam int unsigned CH_W      = 8;
  localparam int unsigned PIX_W     = 3 * CH_W;
  localparam int unsigned SRC_FLD_W = 10;
  localparam int unsigned DST_FLD_W = 11;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 16;

  // Register reset values.
  localparam logic [SRC_FLD_W-1:0] SRC_W_RST = 10'd512;
  localparam logic [SRC_FLD_W-1:0] SRC_H_RST = 10'd512;
  localparam logic [DST_FLD_W-1:0] DST_W_RST = 11'd640;
  localparam logic [DST_FLD_W-1:0] DST_H_RST = 11'd640;

  // Channel value returned in the margins.
  localparam logic [CH_W-1:0] PAD_CODE = 8'd114;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_W = 3'd0,
    CFG_SRC_H = 3'd1,
    CFG_DST_W = 3'd2,
    CFG_DST_H = 3'd3
  } cfg_idx_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_IMAGE = 2'd0,
    ST_PAD   = 2'd1,
    ST_WRITE = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // Geometry unit states.
  typedef enum logic [2:0] {
    GS_SEL,
    GS_LDW,
    GS_DIVW,
    GS_LDH,
    GS_DIVH,
    GS_PAD,
    GS_IDLE
  } geom_state_e;

  // Request word.
  typedef struct packed {
    logic             req_type;
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
    logic [CH_W-1:0]  blue_in;
    logic [CH_W-1:0]  green_in;
    logic [CH_W-1:0]  red_in;
  } req_t;

  // Result word.
  typedef struct packed {
    status_e         status;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
  } rsp_t;

  // Control carried along the pipeline; bgr is packed red, green, blue.
  typedef struct packed {
    status_e          status;
    logic [POS_W-1:0] x_pos;
    logic [POS_W-1:0] y_pos;
    logic [PIX_W-1:0] bgr;
  } pipe_t;

endpackage

>>> src/lnr_geom.sv
// ---------------------------------------------------------------------------
// lnr_geom
// Works out the scale ratio, scaled image size and margins from the
// saturated frame sizes with one shared bit-serial divider.
// ---------------------------------------------------------------------------
module lnr_geom import lnr_pkg::*; #(
  parameter int unsigned SRC_W = 10,
  parameter int unsigned DIM_W = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             restart_i,
  input  logic [SRC_W-1:0] sw_i,
  input  logic [SRC_W-1:0] sh_i,
  input  logic [DIM_W-1:0] dw_i,
  input  logic [DIM_W-1:0] dh_i,
  output logic [DIM_W-1:0] num_o,
  output logic [SRC_W-1:0] den_o,
  output logic [DIM_W-1:0] new_w_o,
  output logic [DIM_W-1:0] new_h_o,
  output logic [DIM_W-1:0] pad_x_o,
  output logic [DIM_W-1:0] pad_y_o,
  output logic             busy_o
);

  localparam int unsigned GW  = SRC_W + DIM_W;
  localparam int unsigned CNW = $clog2(GW + 1);

  geom_state_e state_q, state_d;
  logic [DIM_W-1:0] num_q, new_w_q, new_h_q, pad_x_q, pad_y_q;
  logic [SRC_W-1:0] den_q, rem_q, rem_n;
  logic [GW-1:0]    z_q, z_n;
  logic [CNW-1:0]   cnt_q;
  logic [SRC_W:0]   trial;
  logic             last;
  logic             num_is_w;

  // One restoring division step on the shift register.
  always_comb begin
    trial = {rem_q, z_q[GW-1]};
    if (trial >= {1'b0, den_q}) begin
      rem_n = SRC_W'(trial - {1'b0, den_q});
      z_n   = {z_q[GW-2:0], 1'b1};
    end else begin
      rem_n = trial[SRC_W-1:0];
      z_n   = {z_q[GW-2:0], 1'b0};
    end
  end

  assign last     = (cnt_q == CNW'(GW - 1));
  assign num_is_w = (GW'(dw_i) * GW'(sh_i)) <= (GW'(dh_i) * GW'(sw_i));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      GS_SEL:  state_d = GS_LDW;
      GS_LDW:  state_d = GS_DIVW;
      GS_DIVW: if (last) state_d = GS_LDH;
      GS_LDH:  state_d = GS_DIVH;
      GS_DIVH: if (last) state_d = GS_PAD;
      GS_PAD:  state_d = GS_IDLE;
      GS_IDLE: state_d = GS_IDLE;
      default: state_d = GS_SEL;
    endcase
    if (restart_i) state_d = GS_SEL;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GS_SEL;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath of the geometry sequence.
  always_ff @(posedge clk_i) begin
    case (state_q)
      GS_SEL: begin
        num_q <= num_is_w ? dw_i : dh_i;
        den_q <= num_is_w ? sw_i : sh_i;
      end
      GS_LDW: begin
        z_q   <= GW'(sw_i) * GW'(num_q);
        rem_q <= '0;
        cnt_q <= '0;
      end
      GS_LDH: begin
        z_q   <= GW'(sh_i) * GW'(num_q);
        rem_q <= '0;
        cnt_q <= '0;
      end
      GS_DIVW, GS_DIVH: begin
        z_q   <= z_n;
        rem_q <= rem_n;
        cnt_q <= cnt_q + CNW'(1);
        if (last && state_q == GS_DIVW) new_w_q <= z_n[DIM_W-1:0];
        if (last && state_q == GS_DIVH) new_h_q <= z_n[DIM_W-1:0];
      end
      GS_PAD: begin
        pad_x_q <= (dw_i - new_w_q) >> 1;
        pad_y_q <= (dh_i - new_h_q) >> 1;
      end
      default: ;
    endcase
  end

  // Outputs.
  always_comb begin
    busy_o  = (state_q != GS_IDLE);
    num_o   = num_q;
    den_o   = den_q;
    new_w_o = new_w_q;
    new_h_o = new_h_q;
    pad_x_o = pad_x_q;
    pad_y_o = pad_y_q;
  end

endmodule

>>> src/letterbox_nearest_resize.sv
// ---------------------------------------------------------------------------
// letterbox_nearest_resize
// Frame store with letterboxed nearest-neighbor readout.
// ---------------------------------------------------------------------------
// Words are taken on start while busy is low, one per clock, and each
// gives exactly one result word with rsp_valid_o high for one cycle, in
// order. Each word passes one input register, the pipelined divider (one
// stage per quotient bit, POS_W plus the source size width), one address
// stage and the registered frame store read.
// Results cannot be held off. After reset and after every configuration
// write busy stays high while the scale and margins are recomputed.
// ---------------------------------------------------------------------------
module letterbox_nearest_resize import lnr_pkg::*; #(
  parameter int unsigned MAX_SRC_W   = MAX_SRC_W_DEF,
  parameter int unsigned MAX_SRC_H   = MAX_SRC_H_DEF,
  parameter int unsigned MAX_DST_DIM = MAX_DST_DIM_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  req_t                 req_i,
  output logic                 rsp_valid_o,
  output rsp_t                 rsp_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  localparam int unsigned MAX_SRC = (MAX_SRC_W > MAX_SRC_H) ? MAX_SRC_W : MAX_SRC_H;
  localparam int unsigned SRC_W   = $clog2(MAX_SRC + 1);
  localparam int unsigned DIM_W   = $clog2(MAX_DST_DIM + 1);
  localparam int unsigned CW0     = (POS_W > DIM_W) ? POS_W : DIM_W;
  localparam int unsigned CW      = ((CW0 > SRC_W) ? CW0 : SRC_W) + 1;
  localparam int unsigned PW      = POS_W + SRC_W;
  localparam int unsigned DEPTH   = MAX_SRC_W * MAX_SRC_H;
  localparam int unsigned AW      = $clog2(DEPTH);
  localparam int unsigned RSP_LAT = PW + 3;

  // Configuration registers.
  logic [SRC_FLD_W-1:0] src_w_q, src_h_q;
  logic [DST_FLD_W-1:0] dst_w_q, dst_h_q;
  logic                 cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_w_q <= SRC_W_RST;
      src_h_q <= SRC_H_RST;
      dst_w_q <= DST_W_RST;
      dst_h_q <= DST_H_RST;
    end else if (cfg_wr) begin
      unique case (cfg_index_i)
        CFG_SRC_W: src_w_q <= cfg_data_i[SRC_FLD_W-1:0];
        CFG_SRC_H: src_h_q <= cfg_data_i[SRC_FLD_W-1:0];
        CFG_DST_W: dst_w_q <= cfg_data_i[DST_FLD_W-1:0];
        CFG_DST_H: dst_h_q <= cfg_data_i[DST_FLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturated frame sizes.
  logic [SRC_W-1:0] sw, sh;
  logic [DIM_W-1:0] dw, dh;

  always_comb begin
    if (src_w_q == '0)                 sw = SRC_W'(1);
    else if (int'(src_w_q) > MAX_SRC_W) sw = SRC_W'(MAX_SRC_W);
    else                               sw = SRC_W'(src_w_q);
    if (src_h_q == '0)                 sh = SRC_W'(1);
    else if (int'(src_h_q) > MAX_SRC_H) sh = SRC_W'(MAX_SRC_H);
    else                               sh = SRC_W'(src_h_q);
    if (dst_w_q == '0)                   dw = DIM_W'(1);
    else if (int'(dst_w_q) > MAX_DST_DIM) dw = DIM_W'(MAX_DST_DIM);
    else                                 dw = DIM_W'(dst_w_q);
    if (dst_h_q == '0)                   dh = DIM_W'(1);
    else if (int'(dst_h_q) > MAX_DST_DIM) dh = DIM_W'(MAX_DST_DIM);
    else                                 dh = DIM_W'(dst_h_q);
  end

  // Scale and margins.
  logic [DIM_W-1:0] num, new_w, new_h, pad_x, pad_y;
  logic [SRC_W-1:0] den;

  lnr_geom #(.SRC_W(SRC_W), .DIM_W(DIM_W)) u_geom (
    .clk_i, .rst_ni,
    .restart_i(cfg_wr),
    .sw_i(sw), .sh_i(sh), .dw_i(dw), .dh_i(dh),
    .num_o(num), .den_o(den),
    .new_w_o(new_w), .new_h_o(new_h),
    .pad_x_o(pad_x), .pad_y_o(pad_y),
    .busy_o(busy)
  );

  logic accept;
  assign accept = start && !busy;

  // Classify the incoming word and form the dividends.
  pipe_t          ctl0;
  logic [PW-1:0]  prod_x, prod_y;
  logic [CW-1:0]  xe, ye;

  always_comb begin
    xe = CW'(req_i.x_pos);
    ye = CW'(req_i.y_pos);
    ctl0.x_pos  = req_i.x_pos;
    ctl0.y_pos  = req_i.y_pos;
    ctl0.bgr    = {req_i.red_in, req_i.green_in, req_i.blue_in};
    if (!req_i.req_type) begin
      ctl0.status = (xe < CW'(sw) && ye < CW'(sh)) ? ST_WRITE : ST_RANGE;
    end else if (xe >= CW'(dw) || ye >= CW'(dh)) begin
      ctl0.status = ST_RANGE;
    end else if (xe < CW'(pad_x) || xe >= CW'(pad_x) + CW'(new_w) ||
                 ye < CW'(pad_y) || ye >= CW'(pad_y) + CW'(new_h)) begin
      ctl0.status = ST_PAD;
    end else begin
      ctl0.status = ST_IMAGE;
    end
    prod_x = PW'(POS_W'(xe - CW'(pad_x))) * PW'(den);
    prod_y = PW'(POS_W'(ye - CW'(pad_y))) * PW'(den);
  end

  // Divider pipeline, one quotient bit per stage for both coordinates.
  logic             vld_q [0:PW];
  pipe_t            ctl_q [0:PW];
  logic [PW-1:0]    zx_q  [0:PW];
  logic [PW-1:0]    zy_q  [0:PW];
  logic [DIM_W-1:0] rx_q  [0:PW];
  logic [DIM_W-1:0] ry_q  [0:PW];
  logic [PW-1:0]    zx_n  [1:PW];
  logic [PW-1:0]    zy_n  [1:PW];
  logic [DIM_W-1:0] rx_n  [1:PW];
  logic [DIM_W-1:0] ry_n  [1:PW];

  always_comb begin
    logic [DIM_W:0] tx, ty;
    for (int k = 1; k <= PW; k++) begin
      tx = {rx_q[k-1], zx_q[k-1][PW-1]};
      ty = {ry_q[k-1], zy_q[k-1][PW-1]};
      if (tx >= {1'b0, num}) begin
        rx_n[k] = DIM_W'(tx - {1'b0, num});
        zx_n[k] = {zx_q[k-1][PW-2:0], 1'b1};
      end else begin
        rx_n[k] = tx[DIM_W-1:0];
        zx_n[k] = {zx_q[k-1][PW-2:0], 1'b0};
      end
      if (ty >= {1'b0, num}) begin
        ry_n[k] = DIM_W'(ty - {1'b0, num});
        zy_n[k] = {zy_q[k-1][PW-2:0], 1'b1};
      end else begin
        ry_n[k] = ty[DIM_W-1:0];
        zy_n[k] = {zy_q[k-1][PW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= PW; k++) vld_q[k] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
      for (int k = 1; k <= PW; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    ctl_q[0] <= ctl0;
    zx_q[0]  <= prod_x;
    zy_q[0]  <= prod_y;
    rx_q[0]  <= '0;
    ry_q[0]  <= '0;
    for (int k = 1; k <= PW; k++) begin
      ctl_q[k] <= ctl_q[k-1];
      zx_q[k]  <= zx_n[k];
      zy_q[k]  <= zy_n[k];
      rx_q[k]  <= rx_n[k];
      ry_q[k]  <= ry_n[k];
    end
  end

  // Address stage: clamp the source index or take the write position.
  logic             a_vld_q;
  pipe_t            a_ctl_q;
  logic [AW-1:0]    a_addr_q, a_addr_d;
  logic [SRC_W-1:0] col, row;

  always_comb begin
    if (ctl_q[PW].status == ST_WRITE) begin
      col = SRC_W'(ctl_q[PW].x_pos);
      row = SRC_W'(ctl_q[PW].y_pos);
    end else begin
      col = (zx_q[PW] >= PW'(sw)) ? sw - SRC_W'(1) : SRC_W'(zx_q[PW]);
      row = (zy_q[PW] >= PW'(sh)) ? sh - SRC_W'(1) : SRC_W'(zy_q[PW]);
    end
    a_addr_d = AW'(row) * AW'(MAX_SRC_W) + AW'(col);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else begin
      a_vld_q <= vld_q[PW];
    end
  end

  always_ff @(posedge clk_i) begin
    a_ctl_q  <= ctl_q[PW];
    a_addr_q <= a_addr_d;
  end

  // Frame store: one address a cycle, read every cycle and written on a write.
  logic [PIX_W-1:0] mem [0:DEPTH-1];
  logic [PIX_W-1:0] rdata_q;
  logic             m_vld_q;
  status_e          m_status_q;

  always_ff @(posedge clk_i) begin
    if (a_vld_q && a_ctl_q.status == ST_WRITE) mem[a_addr_q] <= a_ctl_q.bgr;
    rdata_q    <= mem[a_addr_q];
    m_status_q <= a_ctl_q.status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vld_q <= 1'b0;
    end else begin
      m_vld_q <= a_vld_q;
    end
  end

  // Result word.
  always_comb begin
    rsp_valid_o   = m_vld_q;
    rsp_o.status  = m_status_q;
    case (m_status_q)
      ST_IMAGE: {rsp_o.red_out, rsp_o.green_out, rsp_o.blue_out} = rdata_q;
      ST_PAD:   {rsp_o.red_out, rsp_o.green_out, rsp_o.blue_out} =
                  {PAD_CODE, PAD_CODE, PAD_CODE};
      default:  {rsp_o.red_out, rsp_o.green_out, rsp_o.blue_out} = '0;
    endcase
  end

endmodule

>>> src/lnr_checker.sv
// ---------------------------------------------------------------------------
// lnr_checker
// Port-level checks of the resizer: fixed latency and result encoding.
// ---------------------------------------------------------------------------
module lnr_checker import lnr_pkg::*; #(
  parameter int unsigned LAT = 23
) (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic rsp_valid_o,
  input rsp_t rsp_o
);

  // Every result answers a word taken a fixed time earlier.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(start && !busy, LAT))
    else $error("result without a matching request");

  // Padding returns the pad code on all channels.
  a_pad_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status == ST_PAD) |->
      (rsp_o.red_out == PAD_CODE && rsp_o.green_out == PAD_CODE &&
       rsp_o.blue_out == PAD_CODE))
    else $error("padding result without pad code");

  // Writes and range errors carry zero channels.
  a_zero_chan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status == ST_WRITE || rsp_o.status == ST_RANGE)) |->
      (rsp_o.red_out == '0 && rsp_o.green_out == '0 && rsp_o.blue_out == '0))
    else $error("nonzero channels on a status-only result");

endmodule

bind letterbox_nearest_resize lnr_checker #(.LAT(RSP_LAT)) u_lnr_checker (.*);
